FILE: hdl/variable_width_bit_packer_macros.svh
// Assertion macros for the variable-width bit packer.
// Used by the top level; no other dependencies.
`ifndef VARIABLE_WIDTH_BIT_PACKER_MACROS_SVH
`define VARIABLE_WIDTH_BIT_PACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VWBP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bit packer check failed");

// Next-cycle implication, disabled while reset is high.
`define VWBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bit packer check failed");

`endif

FILE: hdl/vwbp_pkg.sv
// Shared types and constants of the variable-width bit packer.
// No dependencies; used by the front end, queue, back end and top-level files.
package vwbp_pkg;

  localparam int VALUE_W = 32;
  localparam int WIDTH_W = 6;
  localparam int BYTE_W = 8;
  localparam int FILL_W = 3;
  localparam int ACC_W = VALUE_W + BYTE_W;
  localparam int TOTAL_W = 6;
  localparam int CNT_W = 3;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH = 6'd32;
  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 6'd8;
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

  // Register index, taken from paddr[2].
  localparam logic REG_VALUE_WIDTH = 1'b0;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic last;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic last_byte;
  } out_word_t;

  // One classified item: the bits to send, how many bytes they make and
  // whether the final byte closes the run.
  typedef struct packed {
    logic [ACC_W-1:0] data;
    logic [CNT_W-1:0] count;
    logic last;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic idle;
  } back_status_t;

endpackage

FILE: hdl/vwbp_front.sv
// Front end of the bit packer: masks each word and merges it with the pending bits.
// Depends on vwbp_pkg.
module vwbp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [vwbp_pkg::WIDTH_W-1:0]   value_width,
  input  logic                           accept,
  input  vwbp_pkg::in_word_t             item,
  output logic                           job_push,
  output vwbp_pkg::job_t                 job
);

  logic [vwbp_pkg::BYTE_W-1:0]  partial_byte;
  logic [vwbp_pkg::FILL_W-1:0]  bits_filled;
  logic [vwbp_pkg::BYTE_W-1:0]  partial_byte_next;

  logic [vwbp_pkg::WIDTH_W-1:0] width;
  logic [vwbp_pkg::VALUE_W-1:0] mask;
  logic [vwbp_pkg::VALUE_W-1:0] masked;
  logic [vwbp_pkg::ACC_W-1:0]   acc;
  logic [vwbp_pkg::TOTAL_W-1:0] total;
  logic [2:0]                   full_bytes;
  logic [vwbp_pkg::FILL_W-1:0]  rem_bits;
  logic                         flush;

  always_comb begin
    width = (value_width > vwbp_pkg::MAX_WIDTH) ? vwbp_pkg::MAX_WIDTH : value_width;
    // A width of zero shifts the whole mask out.
    mask = {vwbp_pkg::VALUE_W{1'b1}} >> (vwbp_pkg::MAX_WIDTH - width);
    masked = item.value & mask;
    acc = {{vwbp_pkg::VALUE_W{1'b0}}, partial_byte}
        | ({{vwbp_pkg::BYTE_W{1'b0}}, masked} << bits_filled);
    total = {{(vwbp_pkg::TOTAL_W - vwbp_pkg::FILL_W){1'b0}}, bits_filled} + width;
    full_bytes = total[vwbp_pkg::TOTAL_W-1:vwbp_pkg::FILL_W];
    rem_bits = total[vwbp_pkg::FILL_W-1:0];
    flush = item.last && (rem_bits != '0);

    job.data = acc;
    job.count = full_bytes + {2'b00, flush};
    job.last = item.last;
    job_push = accept && (job.count != '0);

    // Bits above the filled count are zero already, so the leftover byte
    // is simply the byte after the last full one.
    case (full_bytes)
      3'd0:    partial_byte_next = acc[7:0];
      3'd1:    partial_byte_next = acc[15:8];
      3'd2:    partial_byte_next = acc[23:16];
      3'd3:    partial_byte_next = acc[31:24];
      3'd4:    partial_byte_next = acc[39:32];
      default: partial_byte_next = vwbp_pkg::PAD_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte <= vwbp_pkg::PAD_BYTE;
      bits_filled <= '0;
    end else if (accept) begin
      if (item.last) begin
        partial_byte <= vwbp_pkg::PAD_BYTE;
        bits_filled <= '0;
      end else begin
        partial_byte <= partial_byte_next;
        bits_filled <= rem_bits;
      end
    end
  end

endmodule

FILE: hdl/vwbp_queue.sv
// Short queue of classified jobs between the front and back ends of the bit packer.
// Depends on vwbp_pkg.
module vwbp_queue #(
  parameter int Depth = vwbp_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  vwbp_pkg::job_t          push_job,
  input  logic                    take,
  output vwbp_pkg::job_t          head,
  output vwbp_pkg::queue_status_t status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  vwbp_pkg::job_t mem [Depth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;

  logic do_push;
  logic do_take;

  assign status.empty = (count == '0);
  assign status.full = (count == CntW'(Depth));
  assign do_push = push && !status.full;
  assign do_take = take && !status.empty;
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_take) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/vwbp_back.sv
// Back end: sends each job's bytes one per cycle into the output register while it is free.
// Depends on vwbp_pkg.
module vwbp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  input  vwbp_pkg::job_t         job,
  output logic                   job_take,
  output vwbp_pkg::out_word_t    result,
  output logic                   empty,
  input  logic                   pop,
  output vwbp_pkg::back_status_t status
);

  logic [vwbp_pkg::ACC_W-1:0] cur_data;
  logic [vwbp_pkg::CNT_W-1:0] cur_count;
  logic                       cur_last;
  logic                       out_valid;
  vwbp_pkg::out_word_t        out_reg;

  logic out_ready;
  logic advance;
  logic cur_done;

  always_comb begin
    out_ready = !out_valid || pop;
    advance = out_ready && (cur_count != '0);
    cur_done = (cur_count == '0) || (advance && (cur_count == 3'd1));
    job_take = job_valid && cur_done;
  end

  assign empty = !out_valid;
  assign result = out_reg;
  assign status.idle = (cur_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_take) begin
        cur_count <= job.count;
      end else if (advance) begin
        cur_count <= cur_count - 1'b1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur_data <= job.data;
      cur_last <= job.last;
    end else if (advance) begin
      cur_data <= cur_data >> vwbp_pkg::BYTE_W;
    end
    if (advance) begin
      out_reg.out_byte <= cur_data[vwbp_pkg::BYTE_W-1:0];
      out_reg.last_byte <= cur_last && (cur_count == 3'd1);
    end
  end

endmodule

FILE: hdl/variable_width_bit_packer.sv
// Variable-width bit packer, top level. Uses vwbp_pkg, vwbp_front, vwbp_queue,
// vwbp_back and the assertion macros in variable_width_bit_packer_macros.svh.
//
// Each input word carries a 32-bit value and a last flag; the low value_width bits of
// the value are appended, least significant bit first, to a byte stream. The input
// side is a queue: a word enters when push is high and full is low. The output side is
// a queue too: while empty is low the oldest byte sits on result, and pop takes it.
// value_width is written through the APB port at address 0 (reset value 8; widths
// above 32 count as 32) and may only change while the block is idle.
// The front end merges each word with the pending bits combinationally and queues a job
// holding up to five bytes. The back end serializes one byte per cycle into the output
// register while that register is empty or being popped; a word's first byte passes
// through the job queue and the back end's current-job register before it shows there.
// The byte serializer sets the pace; a word that yields no byte queues nothing.
// When pop stays low the output register holds its byte, the back end stops, the job
// queue fills and full rises. Reset empties the queue and the output register, clears
// the pending bits and restores the width to 8.
`include "variable_width_bit_packer_macros.svh"

module variable_width_bit_packer #(
  parameter int QueueDepth = vwbp_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input word channel.
  input  logic                          push,
  output logic                          full,
  input  vwbp_pkg::in_word_t            item,
  // Output word channel.
  output logic                          empty,
  input  logic                          pop,
  output vwbp_pkg::out_word_t           result,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vwbp_pkg::PADDR_W-1:0]  paddr,
  input  logic [vwbp_pkg::PDATA_W-1:0]  pwdata,
  output logic [vwbp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [vwbp_pkg::WIDTH_W-1:0] value_width;
  logic                         cfg_write;
  logic                         accept;
  logic                         job_push;
  vwbp_pkg::job_t               new_job;
  vwbp_pkg::job_t               head_job;
  logic                         job_take;
  vwbp_pkg::queue_status_t      q_status;
  vwbp_pkg::back_status_t       b_status;

  // The port never inserts wait states. Only the top of the byte address selects a
  // register; the low two bits address bytes inside it.
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_width <= vwbp_pkg::RESET_WIDTH;
    end else if (cfg_write && (paddr[2] == vwbp_pkg::REG_VALUE_WIDTH)) begin
      value_width <= pwdata[vwbp_pkg::WIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == vwbp_pkg::REG_VALUE_WIDTH) begin
      prdata[vwbp_pkg::WIDTH_W-1:0] = value_width;
    end
  end

  // The front end accepts whenever the job queue has room; a word that makes no
  // byte only updates the pending bits and queues nothing.
  assign full = q_status.full;
  assign accept = push && !full;

  vwbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .value_width (value_width),
    .accept      (accept),
    .item        (item),
    .job_push    (job_push),
    .job         (new_job)
  );

  vwbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (new_job),
    .take     (job_take),
    .head     (head_job),
    .status   (q_status)
  );

  vwbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_status.empty),
    .job       (head_job),
    .job_take  (job_take),
    .result    (result),
    .empty     (empty),
    .pop       (pop),
    .status    (b_status)
  );

  // A full queue always has a job to offer the back end.
  `VWBP_ASSERT_NOW(a_full_not_empty, clk, rst, full, !q_status.empty)
  // A back end holding bytes fills an empty output register in the next cycle.
  `VWBP_ASSERT_NEXT(a_back_fills_output, clk, rst, empty && !b_status.idle, !empty)
  // With nothing queued or in progress, taking the last byte leaves the output empty.
  `VWBP_ASSERT_NEXT(a_drain_to_empty, clk, rst,
    pop && !empty && b_status.idle && q_status.empty, empty)

endmodule
